// ===== sv/mgc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgc_pkg
// Shared types, constants and lookup functions for the month grid generator.
// ----------------------------------------------------------------------------
package mgc_pkg;

  localparam int unsigned GRID_CELLS  = 42;
  localparam int unsigned WEEK_LEN    = 7;
  localparam int unsigned MONTHS      = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // floor(x / 100) = (x * RECIP_100) >> 19 for x below 10000
  localparam logic [13:0] RECIP_100 = 14'd5243;
  // floor(x / 7) = (x * RECIP_7) >> 18 for x below 16384
  localparam logic [15:0] RECIP_7   = 16'd37450;

  typedef struct packed {
    logic [13:0] request_year;
    logic [3:0]  request_month;
    logic [4:0]  today_day;
  } req_t;

  typedef struct packed {
    logic [13:0] cell_year;
    logic [3:0]  cell_month;
    logic [4:0]  cell_day;
    logic [2:0]  weekday;
    logic        in_current_month;
    logic        is_today;
    logic        last_cell;
  } cell_t;

  // Everything the back end needs to lay out one month.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  today;
    logic [4:0]  len;
    logic [4:0]  plen;
    logic [2:0]  lead;
  } plan_t;

  typedef enum logic [1:0] {
    SEG_PREV,
    SEG_CUR,
    SEG_NEXT
  } seg_e;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] wd_offset(input logic [3:0] m);
    logic [2:0] o;
    unique case (m)
      4'd1:    o = 3'd0;
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd2;
      4'd4:    o = 3'd5;
      4'd5:    o = 3'd0;
      4'd6:    o = 3'd3;
      4'd7:    o = 3'd5;
      4'd8:    o = 3'd1;
      4'd9:    o = 3'd4;
      4'd10:   o = 3'd6;
      4'd11:   o = 3'd2;
      4'd12:   o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mgc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgc_front
// Two-stage request classifier: clamps the request, finds leap year, month
// lengths and the weekday of the 1st, and hands a plan to the queue.
// ----------------------------------------------------------------------------
module mgc_front import mgc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire req_t  in_data,
  output logic       plan_valid,
  input  wire logic  plan_full,
  output plan_t      plan_data
);

  typedef struct packed {
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  today;
    logic [13:0] yy;
    logic [26:0] prod_y;
    logic [26:0] prod_yy;
  } st1_t;

  typedef struct packed {
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  today;
    logic        leap;
    logic [13:0] s;
    logic [29:0] prod7;
  } st2_t;

  logic v1_r, v1_nxt, v2_r, v2_nxt;
  st1_t st1_r, st1_nxt;
  st2_t st2_r, st2_nxt;
  logic accept, adv1, adv2;

  assign adv2     = v2_r && !plan_full;
  assign adv1     = v1_r && (!v2_r || adv2);
  assign in_stall = v1_r && !adv1;
  assign accept   = in_valid && !in_stall;

  // stage 1: clamp and divide-by-100 products
  always_comb begin
    logic [13:0] y;
    logic [3:0]  m;
    y = in_data.request_year;
    m = in_data.request_month;
    if (y < YEAR_MIN) y = YEAR_MIN;
    if (y > YEAR_MAX) y = YEAR_MAX;
    if (m < 4'd1) m = 4'd1;
    if (m > 4'(MONTHS)) m = 4'(MONTHS);
    st1_nxt.y       = y;
    st1_nxt.m       = m;
    st1_nxt.today   = in_data.today_day;
    st1_nxt.yy      = (m < 4'd3) ? y - 14'd1 : y;
    st1_nxt.prod_y  = 27'(y) * 27'(RECIP_100);
    st1_nxt.prod_yy = 27'(st1_nxt.yy) * 27'(RECIP_100);
  end

  // stage 2: leap year and the day-count sum, then its divide-by-7 product
  always_comb begin
    logic [6:0]  q100y, q100yy;
    logic [13:0] r100;
    q100y  = st1_r.prod_y[25:19];
    q100yy = st1_r.prod_yy[25:19];
    r100   = st1_r.y - 14'(14'(q100y) * 14'd100);
    st2_nxt.y     = st1_r.y;
    st2_nxt.m     = st1_r.m;
    st2_nxt.today = st1_r.today;
    st2_nxt.leap  = ((st1_r.y[1:0] == 2'd0) && (r100 != 14'd0)) ||
                    ((r100 == 14'd0) && (q100y[1:0] == 2'd0));
    st2_nxt.s     = st1_r.yy + (st1_r.yy >> 2) - 14'(q100yy) + 14'(q100yy >> 2)
                    + 14'(wd_offset(st1_r.m)) + 14'd1;
    st2_nxt.prod7 = 30'(st2_nxt.s) * 30'(RECIP_7);
  end

  // plan: weekday remainder and month lengths
  always_comb begin
    logic [10:0] q7;
    logic [2:0]  r7;
    logic [3:0]  pm;
    q7 = st2_r.prod7[28:18];
    r7 = 3'(st2_r.s - 14'(14'(q7) * 14'd7));
    pm = (st2_r.m == 4'd1) ? 4'(MONTHS) : st2_r.m - 4'd1;
    plan_data.year  = st2_r.y;
    plan_data.month = st2_r.m;
    plan_data.today = st2_r.today;
    plan_data.len   = month_len(st2_r.m, st2_r.leap);
    plan_data.plen  = month_len(pm, st2_r.leap);
    plan_data.lead  = (r7 == 3'd0) ? 3'd6 : r7 - 3'd1;
  end

  assign plan_valid = v2_r;

  assign v1_nxt = accept || (v1_r && !adv1);
  assign v2_nxt = adv1 || (v2_r && !adv2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) st1_r <= st1_nxt;
    if (adv1)   st2_r <= st2_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/mgc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgc_queue
// Small plan queue between the classifier and the cell sequencer.
// ----------------------------------------------------------------------------
module mgc_queue import mgc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire plan_t push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output plan_t      pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  plan_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== sv/mgc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgc_back
// Cell sequencer: walks the 42 grid cells of one plan, one per cycle while
// out_stall is low, into a registered output stage.
// ----------------------------------------------------------------------------
module mgc_back import mgc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  plan_avail,
  input  wire plan_t plan_in,
  output logic       plan_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output cell_t      out_data
);

  plan_t       plan_r;
  logic        active_r, active_nxt;
  seg_e        seg_r, seg_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [2:0]  wd_r, wd_nxt;
  logic [5:0]  k_r, k_nxt;
  logic        out_v_r, out_v_nxt;
  cell_t       cell_r, cell_cur;
  logic        step, last;

  // load the next plan while the last cell of the current one goes out
  assign plan_pop = plan_avail && (!active_r || (step && last));
  assign step     = active_r && (!out_v_r || !out_stall);
  assign last     = (k_r == 6'(GRID_CELLS - 1));

  // current cell from the walk position
  always_comb begin
    cell_cur.cell_day         = day_r;
    cell_cur.weekday          = wd_r;
    cell_cur.in_current_month = (seg_r == SEG_CUR);
    cell_cur.is_today         = (seg_r == SEG_CUR) && (day_r == plan_r.today);
    cell_cur.last_cell        = last;
    unique case (seg_r)
      SEG_PREV: begin
        cell_cur.cell_year  = (plan_r.month == 4'd1) ? plan_r.year - 14'd1 : plan_r.year;
        cell_cur.cell_month = (plan_r.month == 4'd1) ? 4'(MONTHS) : plan_r.month - 4'd1;
      end
      SEG_NEXT: begin
        cell_cur.cell_year  = (plan_r.month == 4'(MONTHS)) ? plan_r.year + 14'd1
                                                           : plan_r.year;
        cell_cur.cell_month = (plan_r.month == 4'(MONTHS)) ? 4'd1 : plan_r.month + 4'd1;
      end
      default: begin
        cell_cur.cell_year  = plan_r.year;
        cell_cur.cell_month = plan_r.month;
      end
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    seg_nxt    = seg_r;
    day_nxt    = day_r;
    wd_nxt     = wd_r;
    k_nxt      = k_r;
    if (plan_pop) begin
      active_nxt = 1'b1;
      k_nxt      = '0;
      wd_nxt     = 3'd1;
      if (plan_in.lead == 3'd0) begin
        seg_nxt = SEG_CUR;
        day_nxt = 5'd1;
      end else begin
        seg_nxt = SEG_PREV;
        day_nxt = plan_in.plen - 5'(plan_in.lead) + 5'd1;
      end
    end else if (step) begin
      k_nxt   = k_r + 6'd1;
      wd_nxt  = (wd_r == 3'(WEEK_LEN)) ? 3'd1 : wd_r + 3'd1;
      day_nxt = day_r + 5'd1;
      if (last) active_nxt = 1'b0;
      unique case (seg_r)
        SEG_PREV: begin
          if (day_r == plan_r.plen) begin
            seg_nxt = SEG_CUR;
            day_nxt = 5'd1;
          end
        end
        SEG_CUR: begin
          if (day_r == plan_r.len) begin
            seg_nxt = SEG_NEXT;
            day_nxt = 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_v_nxt = step ? 1'b1 : (out_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      out_v_r  <= 1'b0;
      seg_r    <= SEG_PREV;
      k_r      <= '0;
    end else begin
      active_r <= active_nxt;
      out_v_r  <= out_v_nxt;
      seg_r    <= seg_nxt;
      k_r      <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r <= day_nxt;
    wd_r  <= wd_nxt;
    if (plan_pop) plan_r <= plan_in;
    if (step)     cell_r <= cell_cur;
  end

  assign out_valid = out_v_r;
  assign out_data  = cell_r;

endmodule
`default_nettype wire

// ===== sv/month_grid_cell_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// month_grid_cell_generator
// Monday-first six-week month view: one request in, 42 grid cells out.
// ----------------------------------------------------------------------------
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall  req_t  (year, month, today)
//   out_     out  out_valid/ out_stall cell_t (one grid cell per transaction)
//
// A request passes a two-stage classifier (two multiplier stages) into a
// plan queue; the sequencer then emits one cell per cycle unless stalled.
// Sustained rate: one cell per cycle while out_stall is low; the next plan
// loads into the sequencer together with the last cell of the current one.
// Before the first cell, a request passes both stages, the queue and plan_r.
// Reset is synchronous and clears valid state, walk segment and cell count.
// out_stall holds the output register; a full queue stalls the front.
// ----------------------------------------------------------------------------
module month_grid_cell_generator import mgc_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire req_t  in_data,
  output logic       out_valid,
  input  wire logic  out_stall,
  output cell_t      out_data
);

  logic  plan_valid, plan_full, plan_avail, plan_pop;
  plan_t plan_push_data, plan_head;

  mgc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .plan_valid (plan_valid),
    .plan_full  (plan_full),
    .plan_data  (plan_push_data)
  );

  mgc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (plan_valid),
    .push_data (plan_push_data),
    .full      (plan_full),
    .pop       (plan_pop),
    .not_empty (plan_avail),
    .pop_data  (plan_head)
  );

  mgc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan_avail (plan_avail),
    .plan_in    (plan_head),
    .plan_pop   (plan_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
